@@ hdl/edps_pkg.sv @@
// ----------------------------------------------------------------------------
// edps_pkg
// Shared types and constants of the edge-directed pixel scaler.
// ----------------------------------------------------------------------------
package edps_pkg;

    localparam int COLOR_W  = 24;
    localparam int NB_COUNT = 9;
    localparam int NBHD_W   = COLOR_W * NB_COUNT;

    localparam int MODE_W = 2;

    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [COLOR_W-1:0] color_t;

    // element 0 sits in the lowest bits: raster order of the 3x3 block
    typedef logic [NB_COUNT-1:0][COLOR_W-1:0] nbhd_t;

    localparam mode_t MODE_2X    = 2'd2;
    localparam mode_t MODE_3X    = 2'd3;
    localparam mode_t MODE_RESET = MODE_2X;

endpackage

@@ hdl/edge_directed_pixel_scaler.sv @@
// ----------------------------------------------------------------------------
// edge_directed_pixel_scaler
// Enlarges one source pixel into a 2x2 or 3x3 block of sub-pixels.
// ----------------------------------------------------------------------------
// One item per clock while the output side keeps up: each 3x3 neighborhood
// is held in an input register, passes the scaling rules in one combinational
// step and lands in the output register. scale_mode 3 selects the interpolating
// 3x rules, any other value the Scale2x rules, in which case sub-pixels five to
// nine repeat the centre color. Write scale_mode only while no item is in
// flight.
module edge_directed_pixel_scaler #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [edps_pkg::MODE_W-1:0] cfg_wr_data,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    // nb_up_left, nb_up, nb_up_right, nb_left, centre_pixel, nb_right,
    // nb_down_left, nb_down, nb_down_right; 24 bits each
    input  logic [edps_pkg::NBHD_W-1:0] s_tdata,

    output logic                        m_tvalid,
    input  logic                        m_tready,
    // sub_1 .. sub_9; 24 bits each
    output logic [edps_pkg::NBHD_W-1:0] m_tdata
);

    edps_pkg::mode_t mode_reg;
    logic            in_valid_reg;
    edps_pkg::nbhd_t in_data_reg;
    logic            out_valid_reg;
    edps_pkg::nbhd_t out_data_reg;

    logic            out_advance;
    logic            in_advance;
    edps_pkg::nbhd_t sub_next;

    assign out_advance = !out_valid_reg || m_tready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign s_tready    = in_advance;

    edps_kernel #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_kernel (
        .scale_mode(mode_reg),
        .nb        (in_data_reg),
        .sub       (sub_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= edps_pkg::MODE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (in_advance) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance && s_tvalid) begin
            in_data_reg <= edps_pkg::nbhd_t'(s_tdata);
        end
        if (out_advance && in_valid_reg) begin
            out_data_reg <= sub_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ hdl/edps_kernel.sv @@
// ----------------------------------------------------------------------------
// edps_kernel
// Scale2x corner rules and interpolating 3x rules for one 3x3 neighborhood.
// ----------------------------------------------------------------------------
module edps_kernel #(
    parameter int CHANNEL_BITS = 8
) (
    input  edps_pkg::mode_t scale_mode,
    input  edps_pkg::nbhd_t nb,
    output edps_pkg::nbhd_t sub
);

    localparam int EXT_W  = 3 * CHANNEL_BITS;
    localparam int WIDE_W = (EXT_W > edps_pkg::COLOR_W) ? EXT_W : edps_pkg::COLOR_W;
    localparam int SUM_W  = CHANNEL_BITS + 2;
    localparam int PROD_W = 2 * SUM_W;
    localparam int DIVISOR = 3;
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / DIVISOR);

    function automatic edps_pkg::color_t mean2(edps_pkg::color_t a, edps_pkg::color_t b);
        logic [WIDE_W-1:0]     wa;
        logic [WIDE_W-1:0]     wb;
        logic [WIDE_W-1:0]     r;
        logic [CHANNEL_BITS:0] s;
        wa = WIDE_W'(a);
        wb = WIDE_W'(b);
        r  = '0;
        for (int k = 0; k < 3; k++) begin
            s = (CHANNEL_BITS + 1)'(wa[k*CHANNEL_BITS +: CHANNEL_BITS])
              + (CHANNEL_BITS + 1)'(wb[k*CHANNEL_BITS +: CHANNEL_BITS]);
            r[k*CHANNEL_BITS +: CHANNEL_BITS] = s[CHANNEL_BITS:1];
        end
        return r[edps_pkg::COLOR_W-1:0];
    endfunction

    function automatic edps_pkg::color_t mean3(edps_pkg::color_t a, edps_pkg::color_t b,
                                               edps_pkg::color_t c);
        logic [WIDE_W-1:0]       wa;
        logic [WIDE_W-1:0]       wb;
        logic [WIDE_W-1:0]       wc;
        logic [WIDE_W-1:0]       r;
        logic [SUM_W-1:0]        s;
        logic [PROD_W-1:0]       prod;
        logic [CHANNEL_BITS-1:0] q;
        logic [SUM_W-1:0]        rem;
        wa = WIDE_W'(a);
        wb = WIDE_W'(b);
        wc = WIDE_W'(c);
        r  = '0;
        for (int k = 0; k < 3; k++) begin
            s = SUM_W'(wa[k*CHANNEL_BITS +: CHANNEL_BITS])
              + SUM_W'(wb[k*CHANNEL_BITS +: CHANNEL_BITS])
              + SUM_W'(wc[k*CHANNEL_BITS +: CHANNEL_BITS]);
            // reciprocal estimate is low by at most one
            prod = PROD_W'(s) * PROD_W'(RECIP);
            q    = prod[SUM_W +: CHANNEL_BITS];
            rem  = s - (SUM_W'({q, 1'b0}) + SUM_W'(q));
            if (rem >= SUM_W'(DIVISOR)) begin
                q = q + 1'b1;
            end
            r[k*CHANNEL_BITS +: CHANNEL_BITS] = q;
        end
        return r[edps_pkg::COLOR_W-1:0];
    endfunction

    logic n0, n1, n2, n3, n5, n6, n7, n8;
    logic e13, e37, e75, e51;
    logic any_like;
    logic flat3;
    edps_pkg::nbhd_t sub2;
    edps_pkg::nbhd_t sub3;

    assign n0 = nb[4] != nb[0];
    assign n1 = nb[4] != nb[1];
    assign n2 = nb[4] != nb[2];
    assign n3 = nb[4] != nb[3];
    assign n5 = nb[4] != nb[5];
    assign n6 = nb[4] != nb[6];
    assign n7 = nb[4] != nb[7];
    assign n8 = nb[4] != nb[8];

    assign e13 = (nb[1] == nb[3]) && (n0 || n8 || nb[1] != nb[2] || nb[3] != nb[6]);
    assign e37 = (nb[3] == nb[7]) && (n6 || n2 || nb[3] != nb[0] || nb[7] != nb[8]);
    assign e75 = (nb[7] == nb[5]) && (n8 || n0 || nb[7] != nb[6] || nb[5] != nb[2]);
    assign e51 = (nb[5] == nb[1]) && (n2 || n6 || nb[5] != nb[8] || nb[1] != nb[0]);

    assign any_like = !(n0 && n1 && n2 && n3 && n5 && n6 && n7 && n8);
    assign flat3    = (nb[3] == nb[5]) || (nb[7] == nb[1]);

    always_comb begin
        for (int i = 0; i < edps_pkg::NB_COUNT; i++) begin
            sub2[i] = nb[4];
        end
        if (nb[3] == nb[1] && nb[3] != nb[7] && nb[1] != nb[5]) begin
            sub2[0] = nb[1];
        end
        if (nb[1] == nb[5] && nb[1] != nb[3] && nb[5] != nb[7]) begin
            sub2[1] = nb[5];
        end
        if (nb[7] == nb[3] && nb[7] != nb[5] && nb[3] != nb[1]) begin
            sub2[2] = nb[3];
        end
        if (nb[5] == nb[7] && nb[5] != nb[1] && nb[7] != nb[3]) begin
            sub2[3] = nb[7];
        end
    end

    always_comb begin
        for (int i = 0; i < edps_pkg::NB_COUNT; i++) begin
            sub3[i] = nb[4];
        end
        if (!flat3) begin
            if (e13) begin
                sub3[0] = mean2(nb[1], nb[3]);
            end
            if (e51) begin
                sub3[2] = mean2(nb[5], nb[1]);
            end
            if (e37) begin
                sub3[6] = mean2(nb[3], nb[7]);
            end
            if (e75) begin
                sub3[8] = mean2(nb[7], nb[5]);
            end
            if (any_like) begin
                if (e51 && n0 && e13 && n2) begin
                    sub3[1] = mean3(nb[1], nb[3], nb[5]);
                end else if (e51 && n0) begin
                    sub3[1] = mean2(nb[1], nb[5]);
                end else if (e13 && n2) begin
                    sub3[1] = mean2(nb[1], nb[3]);
                end

                if (e13 && n6 && e37 && n0) begin
                    sub3[3] = mean3(nb[3], nb[1], nb[7]);
                end else if (e13 && n6) begin
                    sub3[3] = mean2(nb[3], nb[1]);
                end else if (e37 && n0) begin
                    sub3[3] = mean2(nb[3], nb[7]);
                end

                if (e75 && n2 && e51 && n8) begin
                    sub3[5] = mean3(nb[5], nb[1], nb[7]);
                end else if (e75 && n2) begin
                    sub3[5] = mean2(nb[5], nb[7]);
                end else if (e51 && n8) begin
                    sub3[5] = mean2(nb[5], nb[1]);
                end

                if (e37 && n8 && e75 && n6) begin
                    sub3[7] = mean3(nb[7], nb[3], nb[5]);
                end else if (e75 && n6) begin
                    sub3[7] = mean2(nb[7], nb[5]);
                end else if (e37 && n8) begin
                    sub3[7] = mean2(nb[7], nb[3]);
                end
            end
        end
    end

    assign sub = (scale_mode == edps_pkg::MODE_3X) ? sub3 : sub2;

endmodule
